// ----- sv/bda_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// shared constants and types for the box downscale averaging core
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int PIX_W = 8;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  // pixel modes
  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_BGR  = 2'd1;
  localparam logic [1:0] MODE_BGRA = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

endpackage

// ----- sv/box_downscale_average_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_average_core
// shrinks a raster pixel stream by s in each direction, one mean per block
// ----------------------------------------------------------------------------
// channel  | direction | payload
// in_      | slave     | tdata: blue, green, red, alpha (8 bits each)
// out_     | master    | tdata: out_blue, out_green, out_red, out_alpha; tlast: frame_end
// cfg_     | slave     | cfg_index selects register, cfg_data holds the value
//
// each pixel has its column-sum memory read as it is taken, then the add and
// write back in the update state; a pixel that closes no block ends there.
// a pixel that closes a block then goes on to the divide: the three means
// come from restoring dividers, one quotient bit a cycle, then the output
// register is loaded, stretched while an earlier result is still held there.
// the output register lets the next pixel in while a result waits; a register
// write is taken only between pixels and holds the input off for that cycle.
// rst_n is synchronous; sum memory needs no clearing pass, the first pixel of
// a block in a strip's top row starts its sums from zero.
// ----------------------------------------------------------------------------
module box_downscale_average_core #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // blue, green, red, alpha
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_blue, out_green, out_red, out_alpha
  output logic        out_tlast,  // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int SB    = $clog2(MAX_SCALE);
  localparam int SUM_W = bda_pkg::PIX_W + 2 * SB;
  localparam int CNT_W = 2 * SB + 1;
  localparam int ITB   = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // configuration
  logic [12:0] width_r;
  logic [15:0] height_r;
  logic [4:0]  scale_r;
  logic [1:0]  mode_r;

  logic [CB:0]   w_eff;
  logic [CB-1:0] w_last;
  logic [SB-1:0] s_last;
  logic [15:0]   h_last;
  logic [1:0]    mode_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = (CB+1)'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = (CB+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CB+1)'(width_r);
    end
    w_last = CB'(w_eff - (CB+1)'(1));
    if (scale_r == '0) begin
      s_last = '0;
    end else if (32'(scale_r) > 32'(MAX_SCALE)) begin
      s_last = SB'(MAX_SCALE - 1);
    end else begin
      s_last = SB'(scale_r - 5'd1);
    end
    h_last   = (height_r == '0) ? 16'd0 : height_r - 16'd1;
    mode_eff = (mode_r == bda_pkg::MODE_RSVD) ? bda_pkg::MODE_BGR : mode_r;
  end

  // traversal and item state
  logic [1:0]    state_r;
  logic [CB-1:0] col_r, oc_r, oc_i_r;
  logic [15:0]   row_r;
  logic [SB-1:0] ris_r, cib_r;
  logic          fresh_i_r, emit_i_r, last_i_r;
  logic [CNT_W-1:0] count_i_r;
  bda_pkg::pixel_t  pix_i_r;
  logic [1:0]    mode_i_r;

  logic cfg_wr, in_acc, last_col, last_row;
  // a register write takes priority over a waiting pixel
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_tready = (state_r == ST_IDLE) & ~cfg_valid;
  assign in_acc    = in_tvalid & in_tready;
  assign last_col  = (cib_r == s_last) || (col_r == w_last);
  assign last_row  = (ris_r == s_last) || (row_r == h_last);

  // column sum memory
  logic [3*SUM_W-1:0] sum_mem [MAX_WIDTH];
  logic [3*SUM_W-1:0] rd_q_r;
  logic [SUM_W-1:0]   sb, sg, sr, nb, ng, nr;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q_r <= sum_mem[oc_r];
    end
    if (state_r == ST_UPD) begin
      sum_mem[oc_i_r] <= {nr, ng, nb};
    end
  end

  always_comb begin
    sb = fresh_i_r ? '0 : rd_q_r[SUM_W-1:0];
    sg = fresh_i_r ? '0 : rd_q_r[2*SUM_W-1:SUM_W];
    sr = fresh_i_r ? '0 : rd_q_r[3*SUM_W-1:2*SUM_W];
    nb = sb + SUM_W'(pix_i_r.blue);
    ng = (mode_i_r == bda_pkg::MODE_GRAY) ? sg : sg + SUM_W'(pix_i_r.green);
    nr = (mode_i_r == bda_pkg::MODE_GRAY) ? sr : sr + SUM_W'(pix_i_r.red);
  end

  // divider: three restoring dividers sharing one count
  logic [SUM_W-1:0] qb_r, qg_r, qr_r;
  logic [CNT_W:0]   rb_r, rg_r, rr_r;
  logic [ITB-1:0]   it_r;
  logic [CNT_W:0]   tb, tg, tr;
  logic             gb, gg, gr;

  always_comb begin
    tb = {rb_r[CNT_W-1:0], qb_r[SUM_W-1]};
    tg = {rg_r[CNT_W-1:0], qg_r[SUM_W-1]};
    tr = {rr_r[CNT_W-1:0], qr_r[SUM_W-1]};
    gb = tb >= {1'b0, count_i_r};
    gg = tg >= {1'b0, count_i_r};
    gr = tr >= {1'b0, count_i_r};
  end

  // output register
  logic out_valid_r, out_last_r;
  bda_pkg::pixel_t out_pix_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      oc_r        <= '0;
      row_r       <= '0;
      ris_r       <= '0;
      cib_r       <= '0;
      out_valid_r <= 1'b0;
      width_r     <= 13'd1;
      height_r    <= 16'd1;
      scale_r     <= 5'd2;
      mode_r      <= bda_pkg::MODE_BGR;
    end else begin
      if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          bda_pkg::REG_WIDTH:  width_r  <= cfg_data[12:0];
          bda_pkg::REG_HEIGHT: height_r <= cfg_data;
          bda_pkg::REG_SCALE:  scale_r  <= cfg_data[4:0];
          bda_pkg::REG_MODE:   mode_r   <= cfg_data[1:0];
        endcase
        col_r <= '0;
        oc_r  <= '0;
        row_r <= '0;
        ris_r <= '0;
        cib_r <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_UPD;
            if (col_r == w_last) begin
              col_r <= '0;
              oc_r  <= '0;
              cib_r <= '0;
              if (row_r == h_last) begin
                row_r <= '0;
                ris_r <= '0;
              end else begin
                row_r <= row_r + 16'd1;
                ris_r <= (ris_r == s_last) ? '0 : ris_r + SB'(1);
              end
            end else begin
              col_r <= col_r + CB'(1);
              if (cib_r == s_last) begin
                cib_r <= '0;
                oc_r  <= oc_r + CB'(1);
              end else begin
                cib_r <= cib_r + SB'(1);
              end
            end
          end
        end
        ST_UPD: begin
          state_r <= emit_i_r ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (it_r == ITB'(SUM_W - 1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_i_r   <= in_tdata;
      mode_i_r  <= mode_eff;
      oc_i_r    <= oc_r;
      fresh_i_r <= (ris_r == '0) && (cib_r == '0);
      emit_i_r  <= last_col && last_row;
      last_i_r  <= (col_r == w_last) && (row_r == h_last);
      count_i_r <= (CNT_W'(ris_r) + CNT_W'(1)) * (CNT_W'(cib_r) + CNT_W'(1));
    end
    if (state_r == ST_UPD) begin
      qb_r <= nb;
      qg_r <= ng;
      qr_r <= nr;
      rb_r <= '0;
      rg_r <= '0;
      rr_r <= '0;
      it_r <= '0;
    end
    if (state_r == ST_DIV) begin
      qb_r <= {qb_r[SUM_W-2:0], gb};
      qg_r <= {qg_r[SUM_W-2:0], gg};
      qr_r <= {qr_r[SUM_W-2:0], gr};
      rb_r <= gb ? tb - {1'b0, count_i_r} : tb;
      rg_r <= gg ? tg - {1'b0, count_i_r} : tg;
      rr_r <= gr ? tr - {1'b0, count_i_r} : tr;
      it_r <= it_r + ITB'(1);
    end
    if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_pix_r.blue  <= qb_r[7:0];
      out_pix_r.green <= (mode_i_r == bda_pkg::MODE_GRAY) ? 8'd0 : qg_r[7:0];
      out_pix_r.red   <= (mode_i_r == bda_pkg::MODE_GRAY) ? 8'd0 : qr_r[7:0];
      out_pix_r.alpha <= (mode_i_r == bda_pkg::MODE_BGRA) ? pix_i_r.alpha : 8'd0;
      out_last_r      <= last_i_r;
    end
  end

endmodule

// ----- sv/bda_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_checker
// port-level checks on the box downscale averaging core
// ----------------------------------------------------------------------------
module bda_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  // one beat at a time: the sum update follows every accepted beat
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken back to back");

  // a result appears only out of the divide, never straight from idle
  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without divide");

endmodule

bind box_downscale_average_core bda_checker u_bda_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready)
);

// ----- test/box_downscale_average_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_average_checker
// watches the pixel, result and register channels of the downscaler, keeps
// its own copy of the block sums and positions, and compares every result
// beat against the oldest predicted output pixel
// ----------------------------------------------------------------------------
module box_downscale_average_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // blue, green, red, alpha
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // out_blue, out_green, out_red, out_alpha
  input  logic        out_tlast,  // frame_end
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    bda_pkg::pixel_t pix;
    logic            frame_end;
  } out_pixel_t;

  out_pixel_t  expected_pixels[$];

  logic [12:0] reg_width;
  logic [15:0] reg_height;
  logic [4:0]  reg_scale;
  logic [1:0]  reg_mode;

  int unsigned col_pos, row_pos, strip_row, block_col;
  int unsigned col_sums[0:4095][0:2];

  assign pending = expected_pixels.size();

  function automatic void restart_frame();
    col_pos   = 0;
    row_pos   = 0;
    strip_row = 0;
    block_col = 0;
    for (int i = 0; i < 4096; i++) begin
      for (int c = 0; c < 3; c++) col_sums[i][c] = 0;
    end
  endfunction

  function automatic void predict_pixel(bda_pkg::pixel_t p);
    int unsigned w, h, s, oc, cnt;
    logic [1:0]  md;
    logic        lc, lr;
    out_pixel_t  o;
    w  = (reg_width == 0) ? 1 : ((reg_width > 4096) ? 4096 : reg_width);
    h  = (reg_height == 0) ? 1 : reg_height;
    s  = (reg_scale == 0) ? 1 : ((reg_scale > 16) ? 16 : reg_scale);
    md = (reg_mode == bda_pkg::MODE_RSVD) ? bda_pkg::MODE_BGR : reg_mode;
    if (col_pos >= w || row_pos >= h || strip_row >= s || block_col >= s) restart_frame();
    oc = (col_pos / s) % 4096;
    col_sums[oc][0] += p.blue;
    if (md != bda_pkg::MODE_GRAY) begin
      col_sums[oc][1] += p.green;
      col_sums[oc][2] += p.red;
    end
    lc = (block_col == s - 1) || (col_pos == w - 1);
    lr = (strip_row == s - 1) || (row_pos == h - 1);
    if (lc && lr) begin
      cnt         = (strip_row + 1) * (block_col + 1);
      o.pix.blue  = 8'(col_sums[oc][0] / cnt);
      o.pix.green = (md != bda_pkg::MODE_GRAY) ? 8'(col_sums[oc][1] / cnt) : 8'd0;
      o.pix.red   = (md != bda_pkg::MODE_GRAY) ? 8'(col_sums[oc][2] / cnt) : 8'd0;
      o.pix.alpha = (md == bda_pkg::MODE_BGRA) ? p.alpha : 8'd0;
      o.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
      expected_pixels.push_back(o);
      for (int c = 0; c < 3; c++) col_sums[oc][c] = 0;
    end
    if (col_pos == w - 1) begin
      col_pos   = 0;
      block_col = 0;
      if (row_pos == h - 1) begin
        row_pos   = 0;
        strip_row = 0;
      end else begin
        row_pos++;
        strip_row = (strip_row == s - 1) ? 0 : strip_row + 1;
      end
    end else begin
      col_pos++;
      block_col = (block_col == s - 1) ? 0 : block_col + 1;
    end
  endfunction

  always @(posedge clk) begin
    bda_pkg::pixel_t got;
    out_pixel_t      exp_pix;
    if (!rst_n) begin
      reg_width  = 1;
      reg_height = 1;
      reg_scale  = 2;
      reg_mode   = bda_pkg::MODE_BGR;
      restart_frame();
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bda_pkg::REG_WIDTH:  reg_width  = cfg_data[12:0];
          bda_pkg::REG_HEIGHT: reg_height = cfg_data;
          bda_pkg::REG_SCALE:  reg_scale  = cfg_data[4:0];
          bda_pkg::REG_MODE:   reg_mode   = cfg_data[1:0];
          default: ;
        endcase
        restart_frame();
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_pixels.size() == 0) begin
          $error("unexpected output beat %h", out_tdata);
          fail_count++;
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (got.blue !== exp_pix.pix.blue) begin
            $error("out_blue: expected %0d, got %0d", exp_pix.pix.blue, got.blue);
            fail_count++;
          end
          if (got.green !== exp_pix.pix.green) begin
            $error("out_green: expected %0d, got %0d", exp_pix.pix.green, got.green);
            fail_count++;
          end
          if (got.red !== exp_pix.pix.red) begin
            $error("out_red: expected %0d, got %0d", exp_pix.pix.red, got.red);
            fail_count++;
          end
          if (got.alpha !== exp_pix.pix.alpha) begin
            $error("out_alpha: expected %0d, got %0d", exp_pix.pix.alpha, got.alpha);
            fail_count++;
          end
          if (out_tlast !== exp_pix.frame_end) begin
            $error("frame_end: expected %0d, got %0d", exp_pix.frame_end, out_tlast);
            fail_count++;
          end
        end
      end
      // a beat out on the same edge as a pixel in is compared before the new prediction
      if (in_tvalid && in_tready) predict_pixel(bda_pkg::pixel_t'(in_tdata));
    end
  end

endmodule

// ----- test/box_downscale_average_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_average_core_tb
// drives register settings and pixel streams into the downscaler, with random
// gaps and back-pressure, and reports the verdict from the checker
// ----------------------------------------------------------------------------
module box_downscale_average_core_tb;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int cycles = 0;
  int pixels_sent;
  bit tx_idle_on;
  int rx_hold_reqs;

  box_downscale_average_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  box_downscale_average_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall per beat, stretches without stalls, one long hold-off
  initial begin
    int gap;
    int beats;
    int holds_done;
    bit rx_idle_on;
    out_tready = 1'b0;
    beats      = 0;
    holds_done = 0;
    rx_idle_on = 1'b1;
    wait (rst_n);
    forever begin
      if (beats % 40 == 0) rx_idle_on = $urandom_range(0, 2) != 0;
      gap = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (rx_hold_reqs > holds_done) begin
        holds_done++;
        gap = 400;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      forever begin
        @(negedge clk);
        if (out_tvalid) break;
      end
      @(posedge clk);
      beats++;
    end
  end

  task automatic send_pixel(logic [31:0] pix);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
    pixels_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain results, then allow for a block still being divided
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int s, int md);
    wait_idle();
    // unused upper data bits carry noise
    write_reg(bda_pkg::REG_WIDTH,  16'(w) | (16'($urandom) & 16'hE000));
    write_reg(bda_pkg::REG_HEIGHT, 16'(h));
    write_reg(bda_pkg::REG_SCALE,  16'(s) | (16'($urandom) & 16'hFFE0));
    write_reg(bda_pkg::REG_MODE,   16'(md) | (16'($urandom) & 16'hFFFC));
  endtask

  initial begin
    int w, h, s, md, n, area;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = bda_pkg::REG_WIDTH;
    cfg_data     = '0;
    pixels_sent  = 0;
    tx_idle_on   = 1'b0;
    rx_hold_reqs = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one pixel per frame
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    // zero sizes and zero scale, gray
    configure(0, 0, 0, bda_pkg::MODE_GRAY);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h55AA_55AA);
    // oversized width and scale, reserved mode
    configure(8191, 1, 31, bda_pkg::MODE_RSVD);
    for (int i = 0; i < 17; i++) send_pixel(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
    // partial blocks at right and bottom edges, alpha passed through
    configure(3, 3, 2, bda_pkg::MODE_BGRA);
    for (int i = 0; i < 9; i++) send_pixel($urandom);

    // long receiver hold-off while every pixel closes a block
    configure(1, 1, 1, bda_pkg::MODE_BGRA);
    rx_hold_reqs++;
    for (int i = 0; i < 60; i++) send_pixel($urandom);

    while (pixels_sent < 540) begin
      case ($urandom_range(0, 9))
        0: begin w = $urandom_range(4096, 8191); h = 1; end
        1: begin w = 0; h = $urandom_range(0, 8); end
        2: begin w = $urandom_range(1, 6); h = $urandom_range(60000, 65535); end
        default: begin w = $urandom_range(1, 20); h = $urandom_range(1, 12); end
      endcase
      s  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      md = $urandom_range(0, 3);
      configure(w, h, s, md);
      tx_idle_on = $urandom_range(0, 3) != 0;
      area = ((w == 0) ? 1 : ((w > 4096) ? 4096 : w)) * ((h == 0) ? 1 : h);
      n = (area <= 150) ? area * $urandom_range(1, 2) + $urandom_range(0, 3)
                        : $urandom_range(20, 120);
      for (int i = 0; i < n; i++) send_pixel($urandom);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bda_pkg.sv
sv/box_downscale_average_core.sv
sv/bda_checker.sv
test/box_downscale_average_checker.sv
test/box_downscale_average_core_tb.sv
